// ----- sv/bth_pkg.sv -----
// Shared types, widths and the divider step for the BGR to HSV pixel core.
package bth_pkg;

  localparam int unsigned ChW       = 8;   // channel width
  localparam int unsigned DvdW      = 11;  // hue dividend, up to 7 * range
  localparam int unsigned NumHW     = 19;  // hue numerator, dividend * 255
  localparam int unsigned DenHW     = 11;  // hue denominator, 6 * range
  localparam int unsigned NumSW     = 16;  // saturation numerator, range * 255
  localparam int unsigned QuoW      = 9;   // quotient bits, hue reaches 297
  localparam int unsigned DivStages = QuoW + 1;      // prep entry plus one per quotient bit
  localparam int unsigned NumVld    = DivStages + 2; // front stage, divider, output
  localparam int unsigned WordW     = 3 * ChW;

  typedef struct packed {
    logic [NumHW-1:0] rem_h;
    logic [DenHW-1:0] den_h;
    logic [QuoW-1:0]  quo_h;
    logic [NumSW-1:0] rem_s;
    logic [ChW-1:0]   den_s;
    logic [QuoW-1:0]  quo_s;
    logic [ChW-1:0]   bright;
    logic             hue_zero;
    logic             sat_zero;
  } div_stage_t;

  // One restoring step on both dividers: resolve quotient bit bitpos.
  function automatic div_stage_t div_step(div_stage_t s, int unsigned bitpos);
    div_stage_t       r;
    logic [NumHW:0]   den_h_sh;
    logic [NumSW:0]   den_s_sh;
    r        = s;
    den_h_sh = (NumHW+1)'(s.den_h) << bitpos;
    den_s_sh = (NumSW+1)'(s.den_s) << bitpos;
    if ({1'b0, s.rem_h} >= den_h_sh) begin
      r.rem_h         = NumHW'({1'b0, s.rem_h} - den_h_sh);
      r.quo_h[bitpos] = 1'b1;
    end
    if ({1'b0, s.rem_s} >= den_s_sh) begin
      r.rem_s         = NumSW'({1'b0, s.rem_s} - den_s_sh);
      r.quo_s[bitpos] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/bgr_to_hsv_pixel_core.sv -----
// BGR to HSV pixel converter: 8-bit hue, saturation and brightness from one pixel.
// Takes one word per clock while the output side is not stalled and returns one
// word per pixel. Two restoring dividers (hue and saturation) resolve one
// quotient bit per stage over nine stages, behind a max/min stage and a
// numerator prep stage.
// Each stage has its own valid bit, so bubbles close up and a stalled output
// holds the pipe without loss. Grey pixels give hue 0, black pixels saturation 0.
module bgr_to_hsv_pixel_core
  import bth_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [WordW-1:0] m_axis_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

  logic [ChW-1:0]  blue, green, red;
  logic [ChW-1:0]  mx, mn, rng;
  logic [DvdW-1:0] dvd;

  logic [ChW-1:0]  mx_q, rng_q;
  logic [DvdW-1:0] dvd_q;

  div_stage_t prep;
  div_stage_t stage_q [DivStages];
  div_stage_t stage_d [DivStages-1];

  logic [NumVld-1:0] vld_q, vld_d, en;
  logic [WordW-1:0]  out_q, out_d;

  assign blue  = s_axis_tdata[ChW-1:0];
  assign green = s_axis_tdata[2*ChW-1:ChW];
  assign red   = s_axis_tdata[3*ChW-1:2*ChW];

  // Front stage: max, min, range and the hue dividend for the winning channel.
  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    rng = mx - mn;
    if (red == mx) begin
      dvd = DvdW'(green) + DvdW'({rng, 2'b00}) + DvdW'({rng, 1'b0}) - DvdW'(blue);
    end else if (green == mx) begin
      dvd = DvdW'(blue) + DvdW'({rng, 1'b0}) - DvdW'(red);
    end else begin
      dvd = DvdW'(red) + DvdW'({rng, 2'b00}) - DvdW'(green);
    end
  end

  // Prep: numerators times 255 by shift and subtract, hue denominator 6 * range.
  always_comb begin
    prep          = '0;
    prep.rem_h    = NumHW'({dvd_q, 8'b0}) - NumHW'(dvd_q);
    prep.den_h    = DenHW'({rng_q, 2'b00}) + DenHW'({rng_q, 1'b0});
    prep.rem_s    = NumSW'({rng_q, 8'b0}) - NumSW'(rng_q);
    prep.den_s    = mx_q;
    prep.bright   = mx_q;
    prep.hue_zero = (rng_q == '0);
    prep.sat_zero = (mx_q == '0);
  end

  always_comb begin
    for (int j = 0; j < DivStages - 1; j++) begin
      stage_d[j] = div_step(stage_q[j], QuoW - 1 - j);
    end
  end

  always_comb begin
    out_d[ChW-1:0]       = stage_q[DivStages-1].hue_zero ? '0
                                                         : stage_q[DivStages-1].quo_h[ChW-1:0];
    out_d[2*ChW-1:ChW]   = stage_q[DivStages-1].sat_zero ? '0
                                                         : stage_q[DivStages-1].quo_s[ChW-1:0];
    out_d[3*ChW-1:2*ChW] = stage_q[DivStages-1].bright;
  end

  // A stage may load when it is empty or its successor loads.
  always_comb begin
    en[NumVld-1] = !vld_q[NumVld-1] || m_axis_tready;
    for (int k = NumVld - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumVld; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mx_q  <= mx;
      rng_q <= rng;
      dvd_q <= dvd;
    end
    if (en[1]) begin
      stage_q[0] <= prep;
    end
    for (int j = 0; j < DivStages - 1; j++) begin
      if (en[j+2]) begin
        stage_q[j+1] <= stage_d[j];
      end
    end
    if (en[NumVld-1]) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NumVld-1];
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_black_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[3*ChW-1:2*ChW] == '0)) |->
      (m_axis_tdata[2*ChW-1:0] == '0))
    else $error("black pixel must give zero hue and saturation");

  a_hue_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumVld-2] && !stage_q[DivStages-1].hue_zero) |->
      (stage_q[DivStages-1].quo_h <= QuoW'(297)))
    else $error("hue quotient out of range");

  a_sat_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumVld-2] && !stage_q[DivStages-1].sat_zero) |->
      (stage_q[DivStages-1].quo_s[QuoW-1] == 1'b0))
    else $error("saturation quotient overflow");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_hold_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumVld-2] && !en[NumVld-1]) |=> vld_q[NumVld-2])
    else $error("divider output dropped during stall");
`endif

endmodule
